// File: hw/rtl/slte_pkg.sv
// Shared types, constants and helpers for the sprite list tile expander.
package slte_pkg;

  localparam int unsigned QueueDepth = 4;

  localparam int unsigned InDataW  = 56;
  localparam int unsigned OutDataW = 40;

  localparam logic [9:0] MirrorPos = 10'd240;
  localparam logic [9:0] TileStep  = 10'd16;
  localparam logic [9:0] RowOffset = 10'd8;

  typedef struct packed {
    logic [11:0] tile_start;
    logic [1:0]  hlog;
    logic [1:0]  wlog;
    logic        fy;
    logic        fx;
    logic [3:0]  colour;
    logic [9:0]  sx;
    logic [9:0]  sy;
  } desc_t;

  function automatic logic [2:0] span_max(input logic [1:0] lg);
    logic [2:0] m;
    unique case (lg)
      2'd0: m = 3'd0;
      2'd1: m = 3'd1;
      2'd2: m = 3'd3;
      2'd3: m = 3'd7;
      default: m = 3'd0;
    endcase
    return m;
  endfunction

endpackage

// File: hw/rtl/slte_front.sv
// Entry decoder: accepts sprite entries, drops hidden ones, builds expansion descriptors.
module slte_front (
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [slte_pkg::InDataW-1:0] s_tdata,
  input  logic                         q_full,
  output logic                         q_push,
  output slte_pkg::desc_t              q_desc
);

  logic [15:0] attr_word;
  logic [15:0] code_word;
  logic [15:0] pos_word;
  logic        frame_odd;
  logic        keep;
  logic [11:0] hmask;
  logic [11:0] base;

  always_comb begin
    attr_word = s_tdata[15:0];
    code_word = s_tdata[31:16];
    pos_word  = s_tdata[47:32];
    frame_odd = s_tdata[48];

    keep  = attr_word[15] && !(pos_word[11] && !frame_odd);
    hmask = {9'd0, slte_pkg::span_max(attr_word[12:11])};
    base  = code_word[11:0] & ~hmask;

    q_desc.tile_start = attr_word[14] ? base : (base | hmask);
    q_desc.hlog       = attr_word[12:11];
    q_desc.wlog       = attr_word[10:9];
    q_desc.fy         = attr_word[14];
    q_desc.fx         = attr_word[13];
    q_desc.colour     = pos_word[15:12];
    q_desc.sx         = slte_pkg::MirrorPos - {pos_word[8], pos_word[8:0]};
    q_desc.sy         = slte_pkg::MirrorPos - slte_pkg::RowOffset
                        - {attr_word[8], attr_word[8:0]};

    s_tready = !q_full;
    q_push   = s_tvalid && s_tready && keep;
  end

endmodule

// File: hw/rtl/slte_queue.sv
// Descriptor queue between the entry decoder and the tile expander.
module slte_queue #(
  parameter int unsigned Depth = slte_pkg::QueueDepth
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  slte_pkg::desc_t push_desc,
  output logic            full,
  input  logic            pop,
  output logic            valid,
  output slte_pkg::desc_t pop_desc
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  slte_pkg::desc_t entries [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic [PtrW-1:0] wr_ptr_next;
  logic [PtrW-1:0] rd_ptr_next;
  logic [CntW-1:0] count_next;

  always_comb begin
    full  = (count == CntW'(Depth));
    valid = (count != '0);
    pop_desc = entries[rd_ptr];

    wr_ptr_next = wr_ptr;
    rd_ptr_next = rd_ptr;
    count_next  = count;
    if (push) begin
      wr_ptr_next = (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
    end
    if (pop) begin
      rd_ptr_next = (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
    end
    if (push && !pop) begin
      count_next = count + 1'b1;
    end else if (pop && !push) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_desc;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CntW'(Depth)) else $error("queue count above depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full) else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> valid) else $error("pop from empty queue");

endmodule

// File: hw/rtl/slte_back.sv
// Tile expander: walks columns and rows of one descriptor, one tile beat per cycle unless m_tready stalls it.
module slte_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_valid,
  input  slte_pkg::desc_t               q_desc,
  output logic                          q_pop,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [slte_pkg::OutDataW-1:0] m_tdata,
  output logic                          m_tlast
);

  slte_pkg::desc_t cur;
  logic            active;
  logic [2:0]      col;
  logic [2:0]      row;
  logic [9:0]      px;
  logic [9:0]      py;
  logic [11:0]     tile;

  logic            active_next;
  logic            m_tvalid_next;
  logic            emit;
  logic            last;
  logic            load;
  logic            row_end;

  always_comb begin
    emit    = active && (!m_tvalid || m_tready);
    row_end = (row == slte_pkg::span_max(cur.hlog));
    last    = row_end && (col == slte_pkg::span_max(cur.wlog));
    load    = q_valid && (!active || (emit && last));
    q_pop   = load;

    active_next = active;
    if (load) begin
      active_next = 1'b1;
    end else if (emit && last) begin
      active_next = 1'b0;
    end

    m_tvalid_next = m_tvalid;
    if (emit) begin
      m_tvalid_next = 1'b1;
    end else if (m_tready) begin
      m_tvalid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active   <= 1'b0;
      m_tvalid <= 1'b0;
      col      <= '0;
      row      <= '0;
    end else begin
      active   <= active_next;
      m_tvalid <= m_tvalid_next;
      if (load || (emit && last)) begin
        col <= '0;
        row <= '0;
      end else if (emit && row_end) begin
        col <= col + 1'b1;
        row <= '0;
      end else if (emit) begin
        row <= row + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur  <= q_desc;
      px   <= q_desc.sx;
      py   <= q_desc.sy;
      tile <= q_desc.tile_start;
    end else if (emit && row_end) begin
      px   <= px - slte_pkg::TileStep;
      py   <= cur.sy;
      tile <= cur.tile_start;
    end else if (emit) begin
      py   <= py - slte_pkg::TileStep;
      tile <= cur.fy ? tile + 1'b1 : tile - 1'b1;
    end
    if (emit) begin
      m_tdata <= {2'b00, cur.colour, cur.fy, cur.fx, py, px, tile};
      m_tlast <= last;
    end
  end

  a_idle_counters: assert property (@(posedge clk) disable iff (rst)
    !active |-> (col == '0) && (row == '0)) else $error("counters busy while idle");

  a_last_ends_run: assert property (@(posedge clk) disable iff (rst)
    emit && last && !load |=> !active) else $error("run continues past last tile");

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    load && active |-> emit && last) else $error("descriptor loaded mid-run");

endmodule

// File: hw/rtl/sprite_list_tile_expander_top.sv
// Top level of the sprite list tile expander.
// An accepted entry is registered in the queue, then in the expander, then at the output.
// Throughput: the entry decoder takes one beat per cycle while the descriptor queue has room.
// The expander emits one tile per cycle unless stalled, and 2^wlog * 2^hlog (1..64) per entry.
// Hidden entries (enable clear, or flash on an even frame) never reach the expander.
// Reset (rst, synchronous) empties the queue, stops the expander and drops the output beat.
module sprite_list_tile_expander_top #(
  parameter int unsigned QueueDepth = slte_pkg::QueueDepth
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // attr_word[15:0], code_word[31:16], pos_word[47:32], frame_odd[48], zero[55:49]
  input  logic [slte_pkg::InDataW-1:0]  s_tdata,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // tile_code[11:0], screen_x[21:12], screen_y[31:22], mirror_x[32], mirror_y[33],
  // colour[37:34], zero[39:38]
  output logic [slte_pkg::OutDataW-1:0] m_tdata,
  output logic                          m_tlast
);

  slte_pkg::desc_t push_desc;
  slte_pkg::desc_t pop_desc;
  logic            q_full;
  logic            q_push;
  logic            q_pop;
  logic            q_valid;

  slte_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_desc   (push_desc)
  );

  slte_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_desc (push_desc),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .pop_desc  (pop_desc)
  );

  slte_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_desc   (pop_desc),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

// File: tb/sprite_list_tile_expander_top_tb.sv
// Testbench for the sprite list tile expander: directed table, random entries, tile checker.
`timescale 1ns / 100ps

module sprite_list_tile_expander_top_tb;

  localparam int unsigned RandomEntries = 450;
  localparam int unsigned CalmTail      = 60;
  localparam int unsigned PauseAt       = 200;
  localparam int unsigned CycleLimit    = 1000000;
  localparam int unsigned DirectedCount = 16;

  typedef struct packed {
    logic [11:0] tile_code;
    logic [9:0]  screen_x;
    logic [9:0]  screen_y;
    logic        mirror_x;
    logic        mirror_y;
    logic [3:0]  colour;
    logic        last_tile;
  } tile_cmd_t;

  typedef struct packed {
    logic [15:0] attr_word;
    logic [15:0] code_word;
    logic [15:0] pos_word;
    logic        frame_odd;
    logic        typed;
    logic        shows;
    tile_cmd_t   tile;
  } entry_row_t;

  localparam entry_row_t DirectedRows [DirectedCount] = '{
    '{16'h8000, 16'h0000, 16'h0000, 1'b0, 1'b1, 1'b1,
      '{12'h000, 10'd240, 10'd232, 1'b0, 1'b0, 4'h0, 1'b1}},
    '{16'hE0FF, 16'hFFFF, 16'hF0FF, 1'b1, 1'b1, 1'b1,
      '{12'hFFF, 10'h3F1, 10'h3E9, 1'b1, 1'b1, 4'hF, 1'b1}},
    '{16'h8100, 16'hE000, 16'h8700, 1'b0, 1'b1, 1'b1,
      '{12'h000, 10'd496, 10'd488, 1'b0, 1'b0, 4'h8, 1'b1}},
    '{16'h7FFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 1'b0, '0},
    '{16'h8000, 16'h0000, 16'h0800, 1'b0, 1'b1, 1'b0, '0},
    '{16'h8000, 16'h0000, 16'h0800, 1'b1, 1'b1, 1'b1,
      '{12'h000, 10'd240, 10'd232, 1'b0, 1'b0, 4'h0, 1'b1}},
    '{16'h8000, 16'h1234, 16'h0000, 1'b0, 1'b1, 1'b1,
      '{12'h234, 10'd240, 10'd232, 1'b0, 1'b0, 4'h0, 1'b1}},
    '{16'h9E00, 16'h1FFF, 16'h5000, 1'b0, 1'b0, 1'b0, '0},
    '{16'hDFFF, 16'h0FFF, 16'hA1FF, 1'b1, 1'b0, 1'b0, '0},
    '{16'hA210, 16'h0003, 16'h3020, 1'b0, 1'b0, 1'b0, '0},
    '{16'h8800, 16'h0005, 16'h0000, 1'b0, 1'b0, 1'b0, '0},
    '{16'hD400, 16'h0123, 16'h6800, 1'b1, 1'b0, 1'b0, '0},
    '{16'h9400, 16'h0123, 16'h6800, 1'b0, 1'b0, 1'b0, '0},
    '{16'h9800, 16'h0FFA, 16'h1000, 1'b0, 1'b0, 1'b0, '0},
    '{16'hD000, 16'h1FFC, 16'h2000, 1'b1, 1'b0, 1'b0, '0},
    '{16'h8B00, 16'h0040, 16'h00FF, 1'b0, 1'b0, 1'b0, '0}
  };

  logic                          clk;
  logic                          rst;
  logic                          s_tvalid;
  logic                          s_tready;
  logic [slte_pkg::InDataW-1:0]  s_tdata;
  logic                          m_tvalid;
  logic                          m_tready;
  logic [slte_pkg::OutDataW-1:0] m_tdata;
  logic                          m_tlast;

  tile_cmd_t   expected_tiles[$];
  int unsigned mismatches;
  int unsigned tiles_checked;
  int unsigned entries_sent;
  int unsigned entries_hidden;
  int unsigned cycle_count;
  int unsigned stall_left;
  bit          calm;

  sprite_list_tile_expander_top uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always #6 clk = ~clk;

  // Expand one entry into its tile commands; returns how many were queued.
  function automatic int unsigned expand_entry(input logic [15:0] attr_word,
                                               input logic [15:0] code_word,
                                               input logic [15:0] pos_word,
                                               input logic frame_odd);
    int unsigned rows;
    int unsigned cols;
    int          x0;
    int          y0;
    int          base;
    int          code;
    int unsigned n;
    tile_cmd_t   t;
    rows = 1 << attr_word[12:11];
    cols = 1 << attr_word[10:9];
    x0   = 240 - int'($signed(pos_word[8:0]));
    y0   = 240 - int'($signed(attr_word[8:0]));
    base = int'(code_word[12:0]) & ~(int'(rows) - 1);
    n    = 0;
    if (!attr_word[15] || (pos_word[11] && !frame_odd)) return 0;
    for (int unsigned c = 0; c < cols; c++) begin
      for (int unsigned r = 0; r < rows; r++) begin
        code        = attr_word[14] ? base + int'(r) : base + int'(rows) - 1 - int'(r);
        t.tile_code = code[11:0];
        t.screen_x  = 10'(x0 - 16 * int'(c));
        t.screen_y  = 10'(y0 - 16 * int'(r) - 8);
        t.mirror_x  = attr_word[13];
        t.mirror_y  = attr_word[14];
        t.colour    = pos_word[15:12];
        t.last_tile = (n + 1 == rows * cols);
        expected_tiles.push_back(t);
        n++;
      end
    end
    return n;
  endfunction

  task automatic send_entry(input logic [15:0] attr_word, input logic [15:0] code_word,
                            input logic [15:0] pos_word, input logic frame_odd);
    int unsigned idle;
    if (!calm && $urandom_range(0, 3) == 0) begin
      idle = $urandom_range(1, 7);
      s_tvalid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {7'd0, frame_odd, pos_word, code_word, attr_word};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    entries_sent++;
  endtask

  // Receiver: check accepted beats, then pick the next tready.
  always @(posedge clk) begin
    tile_cmd_t got;
    tile_cmd_t want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got = '{m_tdata[11:0], m_tdata[21:12], m_tdata[31:22], m_tdata[32], m_tdata[33],
                m_tdata[37:34], m_tlast};
        if (expected_tiles.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected tile beat: code=%h x=%0d y=%0d mx=%b my=%b col=%h last=%b",
                     got.tile_code, $signed(got.screen_x), $signed(got.screen_y),
                     got.mirror_x, got.mirror_y, got.colour, got.last_tile);
        end else begin
          want = expected_tiles.pop_front();
          tiles_checked++;
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"tile mismatch: exp code=%h x=%0d y=%0d mx=%b my=%b col=%h last=%b",
                        " / got code=%h x=%0d y=%0d mx=%b my=%b col=%h last=%b"},
                       want.tile_code, $signed(want.screen_x), $signed(want.screen_y),
                       want.mirror_x, want.mirror_y, want.colour, want.last_tile,
                       got.tile_code, $signed(got.screen_x), $signed(got.screen_y),
                       got.mirror_x, got.mirror_y, got.colour, got.last_tile);
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 6);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d tiles still due", cycle_count,
               expected_tiles.size());
      $display("sprite_list_tile_expander_top test failed");
      $finish;
    end
  end

  initial begin
    logic [15:0]  attr_word;
    logic [15:0]  code_word;
    logic [15:0]  pos_word;
    logic         frame_odd;
    int unsigned  pick;
    int unsigned  shown;
    clk            = 1'b0;
    rst            = 1'b1;
    s_tvalid       = 1'b0;
    s_tdata        = '0;
    m_tready       = 1'b0;
    mismatches     = 0;
    tiles_checked  = 0;
    entries_sent   = 0;
    entries_hidden = 0;
    cycle_count    = 0;
    stall_left     = 0;
    calm           = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (DirectedRows[i]) begin
      send_entry(DirectedRows[i].attr_word, DirectedRows[i].code_word,
                 DirectedRows[i].pos_word, DirectedRows[i].frame_odd);
      if (DirectedRows[i].typed) begin
        shown = DirectedRows[i].shows;
        if (DirectedRows[i].shows) expected_tiles.push_back(DirectedRows[i].tile);
      end else begin
        shown = expand_entry(DirectedRows[i].attr_word, DirectedRows[i].code_word,
                             DirectedRows[i].pos_word, DirectedRows[i].frame_odd);
      end
      if (shown == 0) entries_hidden++;
    end

    for (int unsigned i = 0; i < RandomEntries; i++) begin
      calm = (i >= RandomEntries - CalmTail) || ((i / 40) % 3 == 2);
      if (i == PauseAt) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_tiles.size() != 0) @(posedge clk);
      end
      attr_word = 16'($urandom);
      code_word = 16'($urandom);
      pos_word  = 16'($urandom);
      frame_odd = 1'($urandom);
      pick      = $urandom_range(0, 99);
      // keep most sprites small, a few at the full height of 8 tiles
      if (pick < 65) begin
        attr_word[12:11] = 2'($urandom_range(0, 1));
        attr_word[10:9]  = 2'($urandom_range(0, 1));
      end else if (pick < 95) begin
        attr_word[12:11] = 2'($urandom_range(0, 2));
        attr_word[10:9]  = 2'($urandom_range(0, 2));
      end else begin
        attr_word[12:11] = 2'd3;
        attr_word[10:9]  = 2'($urandom_range(0, 3));
      end
      attr_word[15] = ($urandom_range(0, 99) < 85);
      send_entry(attr_word, code_word, pos_word, frame_odd);
      if (expand_entry(attr_word, code_word, pos_word, frame_odd) == 0) entries_hidden++;
    end
    s_tvalid <= 1'b0;

    while (expected_tiles.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("covered %0d sprite entries (%0d hidden), %0d tile beats checked",
             entries_sent, entries_hidden, tiles_checked);
    $display("mismatches: %0d", mismatches);
    if (mismatches == 0) begin
      $display("sprite_list_tile_expander_top test passed");
    end else begin
      $display("sprite_list_tile_expander_top test failed");
    end
    $finish;
  end

endmodule
